/* rtl/fmn_pkg.sv */
`timescale 1ns / 1ps
package fmn_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 23;
  localparam int unsigned SigW = 24;
  localparam int unsigned ExpW = 8;
  localparam logic [ExpW-1:0] ExpBias = 8'd127;

  typedef struct packed {
    logic              sign;
    logic [ExpW-1:0]   exp;
    logic [SigW-1:0]   sig_a;
    logic [SigW-1:0]   sig_b;
  } unpack_t;

  typedef struct packed {
    logic              sign;
    logic [ExpW-1:0]   exp;
    logic [2*SigW-1:0] prod;
  } mult_t;
endpackage

/* rtl/float32_multiply_normalized_core.sv */
`timescale 1ns / 1ps
// A new operand word is taken every cycle and busy is never raised; each product appears on
// out_product with out_valid once its operands have passed in order through the unpack, the
// 24 by 24 multiply and the normalise-and-round register stages. The receiver cannot stall.
module float32_multiply_normalized_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_product
);
  import fmn_pkg::*;

  logic    s1_vld_r;
  unpack_t s1_r;
  logic    s2_vld;
  mult_t   s2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_r.sign  <= in_operand_a[WordW-1] ^ in_operand_b[WordW-1];
    s1_r.exp   <= in_operand_a[WordW-2:FracW] + in_operand_b[WordW-2:FracW] - ExpBias;
    s1_r.sig_a <= {1'b1, in_operand_a[FracW-1:0]};
    s1_r.sig_b <= {1'b1, in_operand_b[FracW-1:0]};
  end

  fmn_mult u_mult (
    .clk(clk), .rst_n(rst_n), .vld_i(s1_vld_r), .in_i(s1_r), .vld_o(s2_vld), .out_o(s2)
  );

  fmn_round u_round (
    .clk(clk), .rst_n(rst_n), .vld_i(s2_vld), .in_i(s2), .vld_o(out_valid),
    .word_o(out_product)
  );

  assign busy = 1'b0;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##3 out_valid) else $error("product lost");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld |-> $past(s1_vld_r)) else $error("stray product");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
endmodule

/* rtl/fmn_mult.sv */
`timescale 1ns / 1ps
module fmn_mult (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  fmn_pkg::unpack_t in_i,
  output logic           vld_o,
  output fmn_pkg::mult_t out_o
);
  import fmn_pkg::*;

  logic   vld_r;
  mult_t  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    out_r.sign <= in_i.sign;
    out_r.exp  <= in_i.exp;
    out_r.prod <= in_i.sig_a * in_i.sig_b;
  end

  assign vld_o = vld_r;
  assign out_o = out_r;
endmodule

/* rtl/fmn_round.sv */
`timescale 1ns / 1ps
module fmn_round (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           vld_i,
  input  fmn_pkg::mult_t in_i,
  output logic           vld_o,
  output logic [fmn_pkg::WordW-1:0] word_o
);
  import fmn_pkg::*;

  logic              vld_r;
  logic [WordW-1:0]  word_r;
  logic              hi;
  logic [SigW-1:0]   sig;
  logic              rnd;
  logic [SigW:0]     sum;
  logic [ExpW-1:0]   exp;
  logic [FracW-1:0]  frac;

  always_comb begin
    hi  = in_i.prod[2*SigW-1];
    sig = hi ? in_i.prod[2*SigW-1:SigW] : in_i.prod[2*SigW-2:FracW];
    rnd = hi ? in_i.prod[FracW] : in_i.prod[FracW-1];
    sum = {1'b0, sig} + {{SigW{1'b0}}, rnd};
    exp = in_i.exp + {{(ExpW-1){1'b0}}, hi} + {{(ExpW-1){1'b0}}, sum[SigW]};
    frac = sum[SigW] ? sum[SigW-1:1] : sum[FracW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= {in_i.sign, exp, frac};
  end

  assign vld_o  = vld_r;
  assign word_o = word_r;
endmodule

/* bench/float32_multiply_normalized_core_tb.sv */
`timescale 1ns / 1ps
module float32_multiply_normalized_core_tb;
  import fmn_pkg::*;

  typedef struct {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    int               gap;
  } operand_word_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [WordW-1:0] in_operand_a;
  logic [WordW-1:0] in_operand_b;
  logic             out_valid;
  logic [WordW-1:0] out_product;

  operand_word_t    pending_words[$];
  logic [WordW-1:0] expected_products[$];
  int               errors = 0;
  int               products_checked = 0;
  int               gap_left = 0;
  bit               stimulus_done = 0;
  bit               drain_hold = 0;

  float32_multiply_normalized_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid(out_valid),
    .out_product(out_product)
  );

  function automatic logic [WordW-1:0] fmul_product(logic [WordW-1:0] a, logic [WordW-1:0] b);
    logic            sgn;
    logic [ExpW-1:0] e;
    logic [2*SigW-1:0] p;
    logic [SigW:0]   m;
    sgn = a[31] ^ b[31];
    e = a[30:23] + b[30:23] - ExpBias;
    p = {24'd0, 1'b1, a[FracW-1:0]} * {24'd0, 1'b1, b[FracW-1:0]};
    if (p[2*SigW-1]) begin
      e = e + 8'd1;
      m = {1'b0, p[2*SigW-1:SigW]} + {{SigW{1'b0}}, p[FracW]};
    end else begin
      m = {1'b0, p[2*SigW-2:FracW]} + {{SigW{1'b0}}, p[FracW-1]};
    end
    if (m[SigW]) begin
      m = m >> 1;
      e = e + 8'd1;
    end
    return {sgn, e, m[FracW-1:0]};
  endfunction

  function automatic logic [WordW-1:0] rand_operand();
    logic [WordW-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 5))
      0: v[30:23] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      1: v[22:0] = $urandom_range(0, 1) ? 23'h7fffff : 23'h000000;
      2: v[30:23] = 8'($urandom_range(100, 154));
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_word(logic [WordW-1:0] a, logic [WordW-1:0] b, int gap);
    operand_word_t w;
    w.a = a;
    w.b = b;
    w.gap = gap;
    pending_words.push_back(w);
  endtask

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      in_operand_a <= '0;
      in_operand_b <= '0;
    end else if (start && busy) begin
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 0;
    end else if (drain_hold && expected_products.size() != 0) begin
      start <= 0;
    end else if (pending_words.size() != 0) begin
      operand_word_t w;
      w = pending_words.pop_front();
      if (w.gap < 0) begin
        drain_hold <= 1;
        start <= 0;
      end else if (w.gap > 0) begin
        gap_left <= w.gap - 1;
        pending_words.push_front('{w.a, w.b, 0});
        start <= 0;
      end else begin
        drain_hold <= 0;
        start <= 1;
        in_operand_a <= w.a;
        in_operand_b <= w.b;
        expected_products.push_back(fmul_product(w.a, w.b));
      end
    end else begin
      start <= 0;
      stimulus_done <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_products.size() == 0) begin
        $display("%0t: unexpected product %h", $time, out_product);
        errors++;
      end else begin
        logic [WordW-1:0] want;
        want = expected_products.pop_front();
        if (want !== out_product) begin
          $display("%0t: product expected %h actual %h", $time, want, out_product);
          errors++;
        end
        products_checked++;
      end
    end
  end

  initial begin
    int unsigned edges[8];
    int phase_idle;
    int gap;
    edges = '{32'h0000_0000, 32'hffff_ffff, 32'h3f80_0000, 32'hbfff_ffff,
              32'h7f80_0000, 32'h0080_0000, 32'h3fff_ffff, 32'h8000_0001};
    rst_n = 0;
    for (int i = 0; i < 16; i++) begin
      queue_word(edges[i % 8], edges[(i * 3 + 1) % 8], 0);
    end
    queue_word(32'h3fff_ffff, 32'h3f80_0001, 0);
    queue_word(32'h3fc0_0000, 32'h3fc0_0000, 0);
    queue_word(32'h3f80_0001, 32'h3f80_0001, 0);
    queue_word(32'h7f00_0000, 32'h7f00_0000, 0);
    queue_word(32'h0000_0000, 32'h0000_0000, 0);
    queue_word(32'h3fb5_04f3, 32'h3fb5_04f3, 0);
    for (int p = 0; p < 4; p++) begin
      queue_word('0, '0, -1);
      phase_idle = (p == 1) ? 84 : (p == 3 ? 26 : 0);
      for (int i = 0; i < 120; i++) begin
        gap = 0;
        while ($urandom_range(1, 100) <= phase_idle) begin
          gap++;
        end
        queue_word(rand_operand(), rand_operand(), gap);
      end
    end
    repeat (11) @(posedge clk);
    rst_n <= 1;
    wait (stimulus_done && expected_products.size() == 0);
    repeat (10) @(posedge clk);
    $display("Checked %0d products: edge operands, rounding carries, exponent wrap,",
             products_checked);
    $display("and random operand pairs under back-to-back and sparse issue.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
